// ===== sv/ppdr_pkg.sv =====
// Shared types, constants, control store and arc-tangent table for the pose dead-reckoning block.
package ppdr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF  = 16;

    // Datapath widths
    localparam int CW = 32;   // CORDIC x and y, Q2.30
    localparam int ZW = 34;   // CORDIC residual angle
    localparam int MW = 33;   // multiplier operand width
    localparam int PW = 2 * MW;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

    // Microprogram step addresses
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_MUL_RATE = 3'd0;
    localparam t_step ST_MUL_LIN  = 3'd1;
    localparam t_step ST_CINIT    = 3'd2;
    localparam t_step ST_CITER    = 3'd3;
    localparam t_step ST_MUL_COS  = 3'd4;
    localparam t_step ST_ACC_X    = 3'd5;
    localparam t_step ST_ACC_Y    = 3'd6;
    localparam t_step ST_FINISH   = 3'd7;

    // Multiplier operand selection
    typedef logic [2:0] t_mul_sel;

    localparam t_mul_sel MUL_NONE = 3'd0;
    localparam t_mul_sel MUL_RATE = 3'd1;
    localparam t_mul_sel MUL_LIN  = 3'd2;
    localparam t_mul_sel MUL_COS  = 3'd3;
    localparam t_mul_sel MUL_SIN  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_START_X       = 2'd0;
    localparam t_cfg_idx CFG_START_Y       = 2'd1;
    localparam t_cfg_idx CFG_START_HEADING = 2'd2;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ang_upd;
        logic     dist_ld;
        logic     cinit;
        logic     citer;
        logic     acc_x;
        logic     acc_y;
        logic     fin;
        logic     jmp;
        t_step    target;
    } t_ctrl;

    typedef struct packed {
        logic  start;
        t_step start_step;
        logic  iter_last;
        logic  out_free;
    } t_seq_stat;

    function automatic t_ctrl ctrl_rom(input t_step step);
        t_ctrl w;
        w = '0;
        case (step)
            ST_MUL_RATE: begin
                w.mul_sel = MUL_RATE;
            end
            ST_MUL_LIN: begin
                w.mul_sel = MUL_LIN;
                w.ang_upd = 1'b1;
            end
            ST_CINIT: begin
                w.dist_ld = 1'b1;
                w.cinit   = 1'b1;
            end
            ST_CITER: begin
                w.citer  = 1'b1;
                w.jmp    = 1'b1;
                w.target = ST_CITER;
            end
            ST_MUL_COS: begin
                w.mul_sel = MUL_COS;
            end
            ST_ACC_X: begin
                w.acc_x   = 1'b1;
                w.mul_sel = MUL_SIN;
            end
            ST_ACC_Y: begin
                w.acc_y = 1'b1;
            end
            ST_FINISH: begin
                w.fin = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // atan(2^-i) as a fraction of a 32-bit turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41721;
            5'd15:   v = 32'd20860;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2607;
            5'd19:   v = 32'd1303;
            5'd20:   v = 32'd651;
            5'd21:   v = 32'd325;
            5'd22:   v = 32'd162;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ppdr_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module ppdr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppdr_pkg::t_seq_stat i_stat,
    output ppdr_pkg::t_ctrl     o_ctrl,
    output logic                o_busy
);

    ppdr_pkg::t_step r_step;
    ppdr_pkg::t_step n_step;
    logic            r_run;
    logic            n_run;
    ppdr_pkg::t_ctrl rom_word;

    assign rom_word = ppdr_pkg::ctrl_rom(r_step);
    assign o_ctrl   = r_run ? rom_word : '0;
    assign o_busy   = r_run;

    always_comb begin
        n_step = r_step;
        n_run  = r_run;
        if (i_stat.start) begin
            n_step = i_stat.start_step;
            n_run  = 1'b1;
        end else if (r_run) begin
            if (rom_word.fin) begin
                // hold on the last step until the output register frees up
                if (i_stat.out_free) begin
                    n_run = 1'b0;
                end
            end else if (rom_word.jmp && !i_stat.iter_last) begin
                n_step = rom_word.target;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ppdr_pkg::ST_FINISH;
            r_run  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_run  <= n_run;
        end
    end

endmodule

// ===== sv/planar_pose_dead_reckoning.sv =====
// Top level of the planar pose dead-reckoning block: handshakes, datapath and output register.
// Usage
//   Input channel (i_s_axis_*): one tick item per handshake; tuser carries the mode
//   (0 integrate, 1 reload the start pose), tdata active, elapsed time, linear speed
//   and turn rate. Every item yields exactly one result item on o_m_axis_* holding
//   x, y and heading after the tick. Configuration channel (i_cfg_*): writes start_x,
//   start_y and start_heading; always ready; takes effect at the next reload.
// Steps and item flow
//   An integrating item that is active after an active tick runs the microprogram:
//   two multiplies, a CORDIC setup step, TRIG_ITERATIONS shift-add steps, a cosine
//   multiply, a step that adds the x move while forming the sine product, one that
//   adds the y move and a final step; any other item goes straight to the final
//   step. The shared multiplier and the CORDIC loop set this sequence. One item is
//   worked on at a time and the next is accepted the cycle after the result enters
//   the output register.
// Reset and stalls
//   Synchronous active-low reset zeroes the start registers and pose and empties the
//   output register. A stalled receiver holds its result; a new item may still be
//   accepted and worked on, and it waits on its last step until the register frees up.
module planar_pose_dead_reckoning #(
    parameter int ANGLE_BITS      = ppdr_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = ppdr_pkg::TRIG_ITER_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [0] active, [16:1] elapsed, [32:17] lin_speed, [48:33] turn_rate, [55:49] zero
    input  logic [55:0]                    i_s_axis_tdata,
    // [0] mode
    input  logic                           i_s_axis_tuser,
    // result items
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [79:64] heading
    output logic [79:0]                    o_m_axis_tdata,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppdr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    localparam int AB = ANGLE_BITS;
    localparam int IW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
    localparam int CW = ppdr_pkg::CW;
    localparam int ZW = ppdr_pkg::ZW;
    localparam int MW = ppdr_pkg::MW;
    localparam int PW = ppdr_pkg::PW;

    // unpack the input item
    logic               in_active;
    logic [15:0]        in_elapsed;
    logic signed [15:0] in_lin;
    logic signed [15:0] in_rate;
    logic               in_mode;
    logic               in_acc;

    assign in_active  = i_s_axis_tdata[0];
    assign in_elapsed = i_s_axis_tdata[16:1];
    assign in_lin     = i_s_axis_tdata[32:17];
    assign in_rate    = i_s_axis_tdata[48:33];
    assign in_mode    = i_s_axis_tuser;

    // configuration registers
    logic [31:0] r_start_x;
    logic [31:0] r_start_y;
    logic [15:0] r_start_h;

    // pose state
    logic [31:0]   r_x;
    logic [31:0]   r_y;
    logic [AB-1:0] r_angle;
    logic          r_prev_active;

    // latched tick fields
    logic [15:0]        r_elapsed;
    logic signed [15:0] r_lin;
    logic signed [15:0] r_rate;

    // shared datapath
    logic signed [PW-1:0] r_prod;
    logic signed [MW-1:0] r_dist;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_neg;
    logic [IW-1:0]        r_iter;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_x;
    logic [31:0] r_out_y;
    logic [15:0] r_out_h;

    ppdr_pkg::t_ctrl     ctrl;
    ppdr_pkg::t_seq_stat stat;
    logic                busy;
    logic                out_free;
    logic                iter_last;

    ppdr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    assign o_s_axis_tready = !busy;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign iter_last       = (r_iter == IW'(TRIG_ITERATIONS - 1));

    always_comb begin
        stat.start      = in_acc;
        stat.start_step = (!in_mode && in_active && r_prev_active) ?
                          ppdr_pkg::ST_MUL_RATE : ppdr_pkg::ST_FINISH;
        stat.iter_last  = iter_last;
        stat.out_free   = out_free;
    end

    // heading widths are parameter dependent; go through a wide zero-extended copy
    logic [39:0]   start_h_ext;
    logic [39:0]   angle_ext;
    logic [AB-1:0] start_angle;

    assign start_h_ext = 40'(r_start_h);
    assign start_angle = start_h_ext[AB-1:0];
    assign angle_ext   = 40'(r_angle);

    // multiplier operand selection
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [MW-1:0] cx_ext;
    logic signed [MW-1:0] cy_ext;

    assign cx_ext = MW'(r_cx);
    assign cy_ext = MW'(r_cy);

    always_comb begin
        mul_a = MW'(signed'({1'b0, r_elapsed}));
        mul_b = '0;
        case (ctrl.mul_sel)
            ppdr_pkg::MUL_RATE: mul_b = MW'(r_rate);
            ppdr_pkg::MUL_LIN:  mul_b = MW'(r_lin);
            ppdr_pkg::MUL_COS: begin
                mul_a = r_dist;
                mul_b = r_neg ? -cx_ext : cx_ext;
            end
            ppdr_pkg::MUL_SIN: begin
                mul_a = r_dist;
                mul_b = r_neg ? -cy_ext : cy_ext;
            end
            default: mul_b = '0;
        endcase
    end

    // heading step: product over 65536, rounded half up
    logic signed [PW-1:0] ang_sum;
    logic signed [PW-1:0] ang_sh;
    logic [AB-1:0]        ang_next;

    assign ang_sum  = r_prod + PW'(32768);
    assign ang_sh   = ang_sum >>> 16;
    assign ang_next = r_angle + ang_sh[AB-1:0];

    // CORDIC start: scale heading to a 32-bit turn, fold into the right half plane
    logic [31:0] turn;
    logic [31:0] turn_chk;
    logic        fold;
    logic [31:0] turn_fold;

    assign turn      = {r_angle, {(32 - AB){1'b0}}};
    assign turn_chk  = turn + 32'h4000_0000;
    assign fold      = turn_chk[31];
    assign turn_fold = fold ? (turn + 32'h8000_0000) : turn;

    // one CORDIC rotation step
    logic signed [CW-1:0] cx_sh;
    logic signed [CW-1:0] cy_sh;
    logic signed [ZW-1:0] atan_z;

    assign cx_sh  = r_cx >>> r_iter;
    assign cy_sh  = r_cy >>> r_iter;
    assign atan_z = signed'(ZW'(ppdr_pkg::atan_turn(5'(r_iter))));

    // displacement: product over 2^38, rounded half up, then saturating add
    logic signed [PW-1:0] disp_sum;
    logic signed [PW-1:0] disp;
    logic [31:0]          x_next;
    logic [31:0]          y_next;

    assign disp_sum = r_prod + (PW'(1) <<< 37);
    assign disp     = disp_sum >>> 38;

    function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [33:0] d);
        logic [33:0] s;
        s = {{2{acc[31]}}, acc} + d;
        if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
            return s[31:0];
        end else if (s[33]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    assign x_next = sat_add(r_x, disp[33:0]);
    assign y_next = sat_add(r_y, disp[33:0]);

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_h <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppdr_pkg::CFG_START_X:       r_start_x <= i_cfg_data;
                ppdr_pkg::CFG_START_Y:       r_start_y <= i_cfg_data;
                ppdr_pkg::CFG_START_HEADING: r_start_h <= i_cfg_data[15:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x           <= '0;
            r_y           <= '0;
            r_angle       <= '0;
            r_prev_active <= 1'b0;
        end else begin
            if (in_acc) begin
                if (in_mode) begin
                    // reload the start pose, keep prev_active
                    r_x     <= r_start_x;
                    r_y     <= r_start_y;
                    r_angle <= start_angle;
                end else begin
                    r_prev_active <= in_active;
                end
            end
            if (ctrl.ang_upd) begin
                r_angle <= ang_next;
            end
            if (ctrl.acc_x) begin
                r_x <= x_next;
            end
            if (ctrl.acc_y) begin
                r_y <= y_next;
            end
        end
    end

    // tick latch and shared datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elapsed <= in_elapsed;
            r_lin     <= in_lin;
            r_rate    <= in_rate;
        end
        if (ctrl.mul_sel != ppdr_pkg::MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (ctrl.dist_ld) begin
            r_dist <= r_prod[MW-1:0];
        end
        if (ctrl.cinit) begin
            r_cx   <= ppdr_pkg::CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= ZW'(signed'(turn_fold));
            r_neg  <= fold;
            r_iter <= '0;
        end
        if (ctrl.citer) begin
            if (!r_cz[ZW-1]) begin
                r_cx <= r_cx - cy_sh;
                r_cy <= r_cy + cx_sh;
                r_cz <= r_cz - atan_z;
            end else begin
                r_cx <= r_cx + cy_sh;
                r_cy <= r_cy - cx_sh;
                r_cz <= r_cz + atan_z;
            end
            r_iter <= r_iter + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fin && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fin && out_free) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
            r_out_h <= angle_ext[15:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_h, r_out_y, r_out_x};

endmodule

// ===== tb/planar_pose_dead_reckoning_checker.sv =====
`timescale 1ns / 100ps
// Pose checker: watches all channels, predicts each tick's pose and compares the result items.
module planar_pose_dead_reckoning_checker
    import ppdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [55:0] i_in_data,
    input  logic        i_in_user,
    // pose channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [79:0] i_out_data,
    // register writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    // Field order matches the result tdata: x in the low word, heading on top.
    typedef struct packed {
        logic [15:0] hdg;
        logic [31:0] y;
        logic [31:0] x;
    } t_pose;

    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint HALF_LSB38 = 64'sd137438953472;
    localparam longint ATAN_TURN [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860
    };

    logic [31:0] start_x_q;
    logic [31:0] start_y_q;
    logic [15:0] start_hdg_q;
    t_pose       pose;
    logic        moving;
    t_pose       pose_q[$];
    int          fails = 0;
    int          pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    // Shift-add rotation of the gain vector; cos and sin come back in Q2.30.
    function automatic void cos_sin(input logic [15:0] ang, output longint c,
                                    output longint s);
        logic [31:0] turn;
        logic [31:0] probe;
        logic        flip;
        longint      xv;
        longint      yv;
        longint      zv;
        longint      xs;
        longint      ys;
        turn  = {ang, 16'h0000};
        probe = turn + 32'h4000_0000;
        flip  = probe[31];
        // fold the back half-plane onto the front one and negate afterwards
        if (flip) begin
            turn = turn + 32'h8000_0000;
        end
        zv = longint'($signed(turn));
        xv = GAIN_Q30;
        yv = 0;
        for (int i = 0; i < TRIG_ITER_DEF; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (zv >= 0) begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - ATAN_TURN[i];
            end else begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + ATAN_TURN[i];
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] acc, input longint d);
        longint sum;
        sum = longint'($signed(acc)) + d;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
        end
        return sum[31:0];
    endfunction

    function automatic void advance_pose(input logic reload, input logic act,
                                         input logic [15:0] el, input logic [15:0] lin_raw,
                                         input logic [15:0] rate_raw);
        longint e;
        longint l;
        longint r;
        longint turn_step;
        longint travel;
        longint c;
        longint s;
        if (reload) begin
            pose.x   = start_x_q;
            pose.y   = start_y_q;
            pose.hdg = start_hdg_q;
        end else begin
            // pose only moves when the previous tick was active too
            if (act && moving) begin
                e         = el;
                l         = $signed(lin_raw);
                r         = $signed(rate_raw);
                turn_step = (e * r + 64'sd32768) >>> 16;
                pose.hdg  = pose.hdg + turn_step[15:0];
                cos_sin(pose.hdg, c, s);
                travel = e * l;
                pose.x = sat_add32(pose.x, (travel * c + HALF_LSB38) >>> 38);
                pose.y = sat_add32(pose.y, (travel * s + HALF_LSB38) >>> 38);
            end
            moving = act;
        end
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_pose got;
        t_pose want;
        if (!i_rst_n) begin
            start_x_q   = '0;
            start_y_q   = '0;
            start_hdg_q = '0;
            pose        = '0;
            moving      = 1'b0;
            pose_q.delete();
        end else begin
            // the result leaving now belongs to an older tick than one entering now
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fails++;
                end else begin
                    want = pose_q.pop_front();
                    report_field("pos_x", want.x, got.x);
                    report_field("pos_y", want.y, got.y);
                    report_field("heading", 32'(want.hdg), 32'(got.hdg));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_X:       start_x_q   = i_cfg_data;
                    CFG_START_Y:       start_y_q   = i_cfg_data;
                    CFG_START_HEADING: start_hdg_q = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_pose(i_in_user, i_in_data[0], i_in_data[16:1], i_in_data[32:17],
                             i_in_data[48:33]);
                pose_q.push_back(pose);
            end
        end
        pending = pose_q.size();
    end

endmodule

// ===== tb/planar_pose_dead_reckoning_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, tick and register stimulus, result sink and verdict.
module planar_pose_dead_reckoning_tb;
    import ppdr_pkg::*;

    localparam logic     MODE_RUN    = 1'b0;
    localparam logic     MODE_RELOAD = 1'b1;
    localparam t_cfg_idx CFG_NONE    = 2'd3;   // index past the register list
    localparam int       ITEM_TARGET = 1550;
    localparam int       CYCLE_LIMIT = 1000000;
    localparam int       LONG_HOLD   = 300;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [55:0] s_tdata    = '0;
    logic        s_tuser    = 1'b0;
    logic        m_tready   = 1'b0;
    logic        cfg_valid  = 1'b0;
    t_cfg_idx    cfg_index  = CFG_START_X;
    logic [31:0] cfg_data   = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic        cfg_ready;
    int          pending;
    int          fail_count;

    int          sent         = 0;
    logic        sender_quiet = 1'b0;
    int          hold_cycles  = 0;

    planar_pose_dead_reckoning u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    planar_pose_dead_reckoning_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0:                    return 16'h0000;
            1:                    return 16'hFFFF;
            2, 3, 4, 5, 6, 7, 8: return 16'($urandom());
            default:              return 16'($urandom_range(1, 6554));
        endcase
    endfunction

    // Speeds and turn rates: mostly moderate so the pose lives long before it
    // saturates, with full-range and extreme values mixed in.
    function automatic logic [15:0] pick_speed();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3, 4: v = 16'($urandom());
            default: begin
                v = 16'($urandom_range(0, 600));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_reg_value(input t_cfg_idx idx);
        logic [31:0] v;
        v = $urandom();
        if (idx == CFG_START_HEADING) begin
            case ($urandom_range(0, 7))
                0: v[15:0] = 16'h0000;
                1: v[15:0] = 16'hFFFF;
                2: v[15:0] = 16'h4000;
                3: v[15:0] = 16'h8000;
                4: v[15:0] = 16'hC000;
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 7))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = 32'h0000_0000;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Offer one tick item after an optional idle gap and hold it until accepted.
    task automatic send_tick(input logic mode, input logic act, input logic [15:0] el,
                             input logic [15:0] lin, input logic [15:0] rate);
        int g;
        g = sender_quiet ? 0 : pick_gap();
        @(negedge i_clk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, rate, lin, el, act};
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_random_tick();
        int   r;
        logic mode;
        logic act;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            mode = MODE_RELOAD;
            act  = 1'($urandom_range(0, 1));
        end else begin
            mode = MODE_RUN;
            act  = (r >= 12);
        end
        send_tick(mode, act, pick_elapsed(), pick_speed(), pick_speed());
    endtask

    // Drop valid and wait until every accepted tick has its result back.
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Result sink: random stalls with quiet stretches, plus the long hold-off
    // requested by the stimulus so the block backs up into its input.
    initial begin : sink
        int   stall_left;
        int   quiet_left;
        logic quiet;
        stall_left = 0;
        quiet_left = 0;
        quiet      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            if (quiet_left == 0) begin
                quiet      = ($urandom_range(0, 3) == 0);
                quiet_left = $urandom_range(50, 200);
            end else begin
                quiet_left--;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 30) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int       phase;
        int       n_items;
        int       n_writes;
        t_cfg_idx idx;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default start pose, straight out of reset.
        // First active tick after reset: pose holds.
        send_tick(MODE_RUN, 1'b1, 16'd6554, 16'h0100, 16'd1000);
        // Largest positive and negative products.
        send_tick(MODE_RUN, 1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_tick(MODE_RUN, 1'b1, 16'hFFFF, 16'h8000, 16'h8000);
        // Zero elapsed time moves nothing.
        send_tick(MODE_RUN, 1'b1, 16'h0000, 16'h7FFF, 16'h8000);
        // Inactive tick holds, and the next active one holds as well.
        send_tick(MODE_RUN, 1'b0, 16'hFFFF, 16'h1234, 16'h4321);
        send_tick(MODE_RUN, 1'b1, 16'd1000, 16'h0100, 16'h0000);
        send_tick(MODE_RUN, 1'b1, 16'h8000, 16'hFFFF, 16'h0001);
        // Reload ignores its other fields and keeps the active history.
        send_tick(MODE_RELOAD, 1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_tick(MODE_RUN, 1'b1, 16'h5555, 16'h0AAA, 16'hAAAA);
        send_tick(MODE_RELOAD, 1'b0, 16'hAAAA, 16'h5555, 16'h5555);
        send_tick(MODE_RUN, 1'b1, 16'h2000, 16'h0100, 16'h2000);

        // Start at the corners of the range and drive x and y into saturation.
        settle();
        write_reg(CFG_START_X, 32'h7FFF_FFFF);
        write_reg(CFG_START_Y, 32'h8000_0000);
        write_reg(CFG_START_HEADING, 32'hFFFF_2000);
        write_reg(CFG_NONE, 32'hDEAD_BEEF);
        send_tick(MODE_RELOAD, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        repeat (2) send_tick(MODE_RUN, 1'b1, 16'hFFFF, 16'h7FFF, 16'h0000);
        repeat (4) send_tick(MODE_RUN, 1'b1, 16'hFFFF, 16'h8000, 16'h0000);

        // Heading just below a full turn wraps on the next step.
        settle();
        write_reg(CFG_START_HEADING, 32'h0000_FFFF);
        write_reg(CFG_START_X, 32'h0000_0000);
        write_reg(CFG_START_Y, 32'h0000_0000);
        send_tick(MODE_RELOAD, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_tick(MODE_RUN, 1'b1, 16'hFFFF, 16'h0100, 16'h0100);
        send_tick(MODE_RUN, 1'b1, 16'hFFFF, 16'hFF00, 16'hFF00);

        // Random phases: fresh start registers while idle, then a run of ticks.
        phase = 0;
        while (sent < ITEM_TARGET) begin
            settle();
            n_writes = $urandom_range(1, 4);
            repeat (n_writes) begin
                idx = t_cfg_idx'($urandom_range(0, 3));
                write_reg(idx, pick_reg_value(idx));
            end
            sender_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 4) begin
                hold_cycles = LONG_HOLD;
                sender_quiet = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                send_tick(MODE_RELOAD, 1'($urandom_range(0, 1)), pick_elapsed(),
                          pick_speed(), pick_speed());
            end
            n_items = $urandom_range(40, 120);
            repeat (n_items) send_random_tick();
            phase++;
        end

        settle();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
